>>> sv/cdb_command_phase_sequencer_core_macros.svh
// Assertion macros for the command phase sequencer.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef CDB_COMMAND_PHASE_SEQUENCER_CORE_MACROS_SVH
`define CDB_COMMAND_PHASE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication.
`define CDB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication.
`define CDB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

>>> sv/cdb_cps_pkg.sv
// Package for the command phase sequencer: sizes, codes, record and item types.
// Used by the step logic, the top level and the testbench.
package cdb_cps_pkg;

    localparam int MODULE_COUNT     = 32;
    localparam int SLOTS_PER_MODULE = 4;
    localparam int IDX_W            = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READY = 3'd1,
        PH_SEND  = 3'd2,
        PH_RESP  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        RC_OK     = 3'd0,
        RC_BUSY   = 3'd1,
        RC_ABSENT = 3'd2,
        RC_SEND   = 3'd3,
        RC_STATUS = 3'd4,
        RC_RESP   = 3'd5
    } result_t;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_POLL    = 1'b1
    } cmd_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_EXEC
    } seq_state_t;

    // Per-module record; flags are {freeze, retrain, mode}.
    typedef struct packed {
        logic [SLOTS_PER_MODULE-1:0][7:0] slots;
        logic [7:0]                       client;
        logic [2:0]                       flags;
        phase_t                           phase;
    } rec_t;

    typedef struct packed {
        cmd_t       command;
        logic [4:0] module_id;
        logic [7:0] lane_mask;
        logic [7:0] client;
        logic       freeze_flag;
        logic       retrain_flag;
        logic       link_mode;
        logic       module_present;
        logic       busy_bit;
        logic       send_ok;
        logic       status_ok;
        logic       response_ok;
    } item_t;

    typedef struct packed {
        result_t    result_code;
        logic [2:0] phase_now;
        logic       send_strobe;
        logic [7:0] lanes_sent;
        logic [4:0] control_byte;
        logic [7:0] client_out;
    } rsp_t;

endpackage

>>> sv/cdb_cps_req_if.sv
// Request channel of the command phase sequencer: valid/ready plus item fields.
// No dependencies.
interface cdb_cps_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [4:0] module_id;
    logic [7:0] lane_mask;
    logic [7:0] client;
    logic       freeze_flag;
    logic       retrain_flag;
    logic       link_mode;
    logic       module_present;
    logic       busy_bit;
    logic       send_ok;
    logic       status_ok;
    logic       response_ok;

    modport source (
        output valid, command, module_id, lane_mask, client, freeze_flag,
               retrain_flag, link_mode, module_present, busy_bit, send_ok,
               status_ok, response_ok,
        input  ready
    );

    modport sink (
        input  valid, command, module_id, lane_mask, client, freeze_flag,
               retrain_flag, link_mode, module_present, busy_bit, send_ok,
               status_ok, response_ok,
        output ready
    );
endinterface

>>> sv/cdb_cps_rsp_if.sv
// Result channel of the command phase sequencer: valid/ready plus result fields.
// No dependencies.
interface cdb_cps_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] result_code;
    logic [2:0] phase_now;
    logic       send_strobe;
    logic [7:0] lanes_sent;
    logic [4:0] control_byte;
    logic [7:0] client_out;

    modport source (
        output valid, result_code, phase_now, send_strobe, lanes_sent, control_byte,
               client_out,
        input  ready
    );

    modport sink (
        input  valid, result_code, phase_now, send_strobe, lanes_sent, control_byte,
               client_out,
        output ready
    );
endinterface

>>> sv/cdb_cps_step.sv
// One phase step on a module record: new record, write enable and result.
// Depends on cdb_cps_pkg.
module cdb_cps_step (
    input  cdb_cps_pkg::item_t item,
    input  cdb_cps_pkg::rec_t  rec_old,
    output cdb_cps_pkg::rec_t  rec_new,
    output logic               wr_en,
    output cdb_cps_pkg::rsp_t  rsp
);
    import cdb_cps_pkg::*;

    logic       out_of_range;
    logic       slot_found;
    logic       any_pending;
    logic [7:0] merged;

    assign out_of_range = int'(item.module_id) >= MODULE_COUNT;

    always_comb
    begin
        slot_found  = 1'b0;
        any_pending = 1'b0;
        merged      = '0;
        rec_new     = rec_old;
        wr_en       = 1'b0;
        rsp         = '0;
        rsp.result_code = RC_OK;

        for (int s = 0; s < SLOTS_PER_MODULE; s++)
        begin
            merged      = merged | rec_old.slots[s];
            any_pending = any_pending | (rec_old.slots[s] != 8'd0);
        end

        if (out_of_range)
        begin
            rsp.result_code = RC_ABSENT;
        end
        else
        begin
            unique case (item.command)
                CMD_ENQUEUE:
                begin
                    if (!item.module_present)
                    begin
                        rsp.result_code = RC_ABSENT;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        // fill the first empty slot; drop the mask when all are full
                        for (int s = 0; s < SLOTS_PER_MODULE; s++)
                        begin
                            if (!slot_found && rec_old.slots[s] == 8'd0)
                            begin
                                rec_new.slots[s] = item.lane_mask;
                                slot_found       = 1'b1;
                            end
                        end
                        if (rec_old.phase == PH_IDLE)
                        begin
                            rec_new.client = item.client;
                            rec_new.flags  = {item.freeze_flag,
                                              item.retrain_flag, item.link_mode};
                            rec_new.phase  = PH_READY;
                        end
                    end
                end
                CMD_POLL:
                begin
                    wr_en = 1'b1;
                    unique case (rec_old.phase)
                        PH_READY:
                        begin
                            if (!item.module_present)
                            begin
                                rsp.result_code = RC_ABSENT;
                                rec_new.phase   = PH_DONE;
                            end
                            else if (item.busy_bit)
                                rsp.result_code = RC_BUSY;
                            else
                                rec_new.phase = PH_SEND;
                        end
                        PH_SEND:
                        begin
                            if (!item.module_present)
                            begin
                                rsp.result_code = RC_ABSENT;
                                rec_new.phase   = PH_DONE;
                            end
                            else
                            begin
                                // issue the merged block even when the write fails
                                rec_new.slots    = '0;
                                rsp.send_strobe  = 1'b1;
                                rsp.lanes_sent   = merged;
                                rsp.control_byte = {rec_old.flags[2], 2'b00,
                                                    rec_old.flags[1], rec_old.flags[0]};
                                if (!item.send_ok)
                                begin
                                    rsp.result_code = RC_SEND;
                                    rec_new.phase   = PH_DONE;
                                end
                                else
                                    rec_new.phase = PH_RESP;
                            end
                        end
                        PH_RESP:
                        begin
                            if (!item.module_present)
                            begin
                                rsp.result_code = RC_ABSENT;
                                rec_new.phase   = PH_DONE;
                            end
                            else if (item.busy_bit)
                                rsp.result_code = RC_BUSY;
                            else
                            begin
                                rec_new.phase = PH_DONE;
                                if (!item.status_ok)
                                    rsp.result_code = RC_STATUS;
                                else if (!item.response_ok)
                                    rsp.result_code = RC_RESP;
                            end
                        end
                        PH_DONE:
                        begin
                            rec_new.phase = any_pending ? PH_READY : PH_IDLE;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
            rsp.phase_now  = rec_new.phase;
            rsp.client_out = rec_new.client;
        end
    end

endmodule

>>> sv/cdb_command_phase_sequencer_core.sv
// Command phase sequencer top level: record memory, control and result register.
// Depends on cdb_cps_pkg, cdb_cps_req_if, cdb_cps_rsp_if, cdb_cps_step and the macro header.
`include "cdb_command_phase_sequencer_core_macros.svh"

// Each request first reads the module's record from the record memory into a register,
// then runs the phase step and writes the record back. The
// result goes to an output register, so a new request is taken as soon as the
// previous record is written, even while its result still waits to be taken; the
// step stalls only while that register is still full. Reset clears one valid bit per
// module at once, and a module whose bit is clear reads as idle with empty slots,
// zero client and zero flags, so no clearing pass is needed.
module cdb_command_phase_sequencer_core (
    input  logic          clk,
    input  logic          rst_n,
    cdb_cps_req_if.sink   req,
    cdb_cps_rsp_if.source rsp
);
    import cdb_cps_pkg::*;

    seq_state_t            state_reg;
    seq_state_t            state_next;
    item_t                 item_reg;
    rec_t                  rd_rec_reg;
    logic                  rd_vld_reg;
    logic [MODULE_COUNT-1:0] vld_reg;
    rec_t                  rec_mem [MODULE_COUNT];
    rec_t                  rec_old;
    rec_t                  rec_new;
    logic                  step_wr;
    rsp_t                  step_rsp;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg;
    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic [IDX_W-1:0]      idx_in;
    logic [IDX_W-1:0]      idx_item;
    item_t                 item_in;

    assign idx_in   = req.module_id[IDX_W-1:0];
    assign idx_item = item_reg.module_id[IDX_W-1:0];
    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign item_in.command            = cmd_t'(req.command);
    assign item_in.module_id          = req.module_id;
    assign item_in.lane_mask          = req.lane_mask;
    assign item_in.client             = req.client;
    assign item_in.freeze_flag        = req.freeze_flag;
    assign item_in.retrain_flag       = req.retrain_flag;
    assign item_in.link_mode          = req.link_mode;
    assign item_in.module_present     = req.module_present;
    assign item_in.busy_bit           = req.busy_bit;
    assign item_in.send_ok            = req.send_ok;
    assign item_in.status_ok          = req.status_ok;
    assign item_in.response_ok        = req.response_ok;

    // never-written records read as the reset record
    assign rec_old = rd_vld_reg ? rd_rec_reg : '0;

    cdb_cps_step u_step (
        .item    (item_reg),
        .rec_old (rec_old),
        .rec_new (rec_new),
        .wr_en   (step_wr),
        .rsp     (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SQ_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = SQ_EXEC;
            end
            SQ_EXEC:
            begin
                // hold the step until the result register can take it
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                rd_vld_reg <= vld_reg[idx_in];
            if (commit && step_wr)
                vld_reg[idx_item] <= 1'b1;
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= item_in;
            rd_rec_reg <= rec_mem[idx_in];
        end
        if (commit && step_wr)
            rec_mem[idx_item] <= rec_new;
        if (commit)
            rsp_reg <= step_rsp;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_code  = rsp_reg.result_code;
    assign rsp.phase_now    = rsp_reg.phase_now;
    assign rsp.send_strobe  = rsp_reg.send_strobe;
    assign rsp.lanes_sent   = rsp_reg.lanes_sent;
    assign rsp.control_byte = rsp_reg.control_byte;
    assign rsp.client_out   = rsp_reg.client_out;

    `CDB_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == SQ_EXEC)
    `CDB_ASSERT_IMPL(a_result_from_step, rsp.valid && !$past(rsp.valid),
        $past(state_reg == SQ_EXEC))
    `CDB_ASSERT_IMPL(a_strobe_code, rsp.valid && rsp.send_strobe,
        rsp.result_code == RC_OK || rsp.result_code == RC_SEND)
    `CDB_ASSERT_IMPL(a_strobe_phase, rsp.valid && rsp.send_strobe,
        rsp.phase_now == PH_RESP || rsp.phase_now == PH_DONE)
    `CDB_ASSERT_IMPL(a_no_write_unless_exec, commit, state_reg == SQ_EXEC && out_free)

endmodule

>>> sim/tb.sv
// Self-checking testbench for cdb_command_phase_sequencer_core: directed phase walks,
// then random enqueue/poll traffic under varied idling and a long result stall.
// Depends on cdb_cps_pkg, cdb_cps_req_if, cdb_cps_rsp_if and the sequencer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdb_cps_pkg::*;

    localparam int QUIET_LIMIT    = 1500;
    localparam int RANDOM_ITEMS   = 650;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;

    // Sensed bits: {present, busy, send_ok, status_ok, response_ok}
    localparam logic [4:0] ST_GOOD        = 5'b10111;
    localparam logic [4:0] ST_BUSY        = 5'b11111;
    localparam logic [4:0] ST_ABSENT      = 5'b00111;
    localparam logic [4:0] ST_SEND_FAIL   = 5'b10011;
    localparam logic [4:0] ST_STATUS_FAIL = 5'b10101;
    localparam logic [4:0] ST_RESP_FAIL   = 5'b10110;

    class sequencer_scoreboard;
        phase_t     mod_phase  [MODULE_COUNT];
        logic [7:0] mod_slots  [MODULE_COUNT][SLOTS_PER_MODULE];
        logic [7:0] mod_client [MODULE_COUNT];
        logic [2:0] mod_flags  [MODULE_COUNT];
        rsp_t       due_results[$];
        int unsigned errors;
        int unsigned n_requests;
        int unsigned n_enqueues;
        int unsigned n_blocks;
        int unsigned n_failures;

        function new();
            foreach (mod_phase[m])
            begin
                mod_phase[m]  = PH_IDLE;
                mod_client[m] = '0;
                mod_flags[m]  = '0;
                for (int s = 0; s < SLOTS_PER_MODULE; s++)
                    mod_slots[m][s] = '0;
            end
        endfunction

        // Advance the module record by one request and queue the result it yields.
        function void log_request(item_t it);
            rsp_t       e;
            int         m;
            phase_t     ph;
            bit         placed;
            bit         waiting;
            logic [2:0] fl;

            m  = it.module_id;
            ph = mod_phase[m];
            e  = '0;
            e.result_code = RC_OK;
            n_requests++;
            if (it.command == CMD_ENQUEUE)
            begin
                n_enqueues++;
                if (!it.module_present)
                    e.result_code = RC_ABSENT;
                else
                begin
                    placed = 0;
                    for (int s = 0; s < SLOTS_PER_MODULE; s++)
                    begin
                        if (!placed && mod_slots[m][s] == 8'h00)
                        begin
                            mod_slots[m][s] = it.lane_mask;
                            placed = 1;
                        end
                    end
                    if (ph == PH_IDLE)
                    begin
                        mod_client[m] = it.client;
                        mod_flags[m]  = {it.freeze_flag, it.retrain_flag,
                                         it.link_mode};
                        mod_phase[m]  = PH_READY;
                    end
                end
            end
            else
            begin
                case (ph)
                    PH_READY:
                    begin
                        if (!it.module_present)
                        begin
                            e.result_code = RC_ABSENT;
                            mod_phase[m]  = PH_DONE;
                        end
                        else if (it.busy_bit)
                            e.result_code = RC_BUSY;
                        else
                            mod_phase[m] = PH_SEND;
                    end
                    PH_SEND:
                    begin
                        if (!it.module_present)
                        begin
                            e.result_code = RC_ABSENT;
                            mod_phase[m]  = PH_DONE;
                        end
                        else
                        begin
                            // merge and clear; the block counts as issued even if the write fails
                            for (int s = 0; s < SLOTS_PER_MODULE; s++)
                            begin
                                e.lanes_sent    |= mod_slots[m][s];
                                mod_slots[m][s] = '0;
                            end
                            fl = mod_flags[m];
                            e.control_byte = {fl[2], 2'b00, fl[1], fl[0]};
                            e.send_strobe  = 1'b1;
                            n_blocks++;
                            if (!it.send_ok)
                            begin
                                e.result_code = RC_SEND;
                                mod_phase[m]  = PH_DONE;
                            end
                            else
                                mod_phase[m] = PH_RESP;
                        end
                    end
                    PH_RESP:
                    begin
                        if (!it.module_present)
                        begin
                            e.result_code = RC_ABSENT;
                            mod_phase[m]  = PH_DONE;
                        end
                        else if (it.busy_bit)
                            e.result_code = RC_BUSY;
                        else
                        begin
                            if (!it.status_ok)
                                e.result_code = RC_STATUS;
                            else if (!it.response_ok)
                                e.result_code = RC_RESP;
                            mod_phase[m] = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        waiting = 0;
                        for (int s = 0; s < SLOTS_PER_MODULE; s++)
                            if (mod_slots[m][s] != 8'h00)
                                waiting = 1;
                        mod_phase[m] = waiting ? PH_READY : PH_IDLE;
                    end
                    default: ;
                endcase
            end
            if (e.result_code != RC_OK)
                n_failures++;
            e.phase_now  = mod_phase[m];
            e.client_out = mod_client[m];
            due_results.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;

            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result code=%0d phase=%0d", $realtime,
                             got.result_code, got.phase_now);
                return;
            end
            e = due_results.pop_front();
            if (got.result_code != e.result_code || got.phase_now != e.phase_now ||
                got.send_strobe != e.send_strobe || got.lanes_sent != e.lanes_sent ||
                got.control_byte != e.control_byte || got.client_out != e.client_out)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display({"%0t: mismatch expected code=%0d phase=%0d strobe=%0d",
                              " lanes=%h ctrl=%h client=%h"},
                             $realtime, e.result_code, e.phase_now, e.send_strobe,
                             e.lanes_sent, e.control_byte, e.client_out);
                    $display({"%0t:          actual   code=%0d phase=%0d strobe=%0d",
                              " lanes=%h ctrl=%h client=%h"},
                             $realtime, got.result_code, got.phase_now, got.send_strobe,
                             got.lanes_sent, got.control_byte, got.client_out);
                end
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_wanted;
    bit   hold_taken;

    sequencer_scoreboard sb;

    cdb_cps_req_if req_ch();
    cdb_cps_rsp_if rsp_ch();

    cdb_command_phase_sequencer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Score both channels on the rising edge, results first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.result_code, rsp_ch.phase_now, rsp_ch.send_strobe,
                                 rsp_ch.lanes_sent, rsp_ch.control_byte, rsp_ch.client_out});
            if (req_ch.valid && req_ch.ready)
                sb.log_request({req_ch.command, req_ch.module_id, req_ch.lane_mask,
                                req_ch.client, req_ch.freeze_flag,
                                req_ch.retrain_flag, req_ch.link_mode,
                                req_ch.module_present, req_ch.busy_bit, req_ch.send_ok,
                                req_ch.status_ok, req_ch.response_ok});
        end
    end

    // Result side: random stalls, plus one long hold when asked.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        hold_taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1;
                rsp_ch.ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(negedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when no request and no result moves for too long.
    initial
    begin
        int quiet;

        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic item_t make_item(cmd_t c, int mod, logic [7:0] mask,
                                        logic [7:0] cl, logic [2:0] fl, logic [4:0] st);
        item_t it;

        it.command            = c;
        it.module_id          = mod[4:0];
        it.lane_mask          = mask;
        it.client             = cl;
        {it.freeze_flag, it.retrain_flag, it.link_mode} = fl;
        {it.module_present, it.busy_bit, it.send_ok, it.status_ok, it.response_ok} = st;
        return it;
    endfunction

    // Mostly a few modules so each gets walked through its phases; mostly good status.
    function automatic item_t random_item();
        item_t      it;
        int         mod;
        logic [7:0] mask;
        int         pick;

        mod  = ($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(31);
        pick = $urandom_range(9);
        mask = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        it = make_item(($urandom_range(99) < 60) ? CMD_POLL : CMD_ENQUEUE, mod, mask,
                       8'($urandom), 3'($urandom),
                       {$urandom_range(99) < 92, $urandom_range(99) < 20,
                        $urandom_range(99) < 88, $urandom_range(99) < 88,
                        $urandom_range(99) < 88});
        return it;
    endfunction

    // Enter at a falling edge, leave at the falling edge after the request is taken.
    task automatic offer_request(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        {req_ch.command, req_ch.module_id, req_ch.lane_mask, req_ch.client,
         req_ch.freeze_flag, req_ch.retrain_flag, req_ch.link_mode,
         req_ch.module_present, req_ch.busy_bit, req_ch.send_ok, req_ch.status_ok,
         req_ch.response_ok} <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        item_t walk[$];

        sb = new();
        hold_wanted   = 0;
        send_idle_pct = 27;
        recv_idle_pct = 64;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        {req_ch.command, req_ch.module_id, req_ch.lane_mask, req_ch.client,
         req_ch.freeze_flag, req_ch.retrain_flag, req_ch.link_mode,
         req_ch.module_present, req_ch.busy_bit, req_ch.send_ok, req_ch.status_ok,
         req_ch.response_ok} <= '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Module 5: idle poll, absent enqueue, overfilled slots, busy, failed send.
        walk.push_back(make_item(CMD_POLL,    5, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_ENQUEUE, 5, 8'hFF, 8'hFF, 3'b111, ST_ABSENT));
        walk.push_back(make_item(CMD_ENQUEUE, 5, 8'hFF, 8'hFF, 3'b111, ST_GOOD));
        walk.push_back(make_item(CMD_ENQUEUE, 5, 8'h01, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_ENQUEUE, 5, 8'h80, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_ENQUEUE, 5, 8'h10, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_ENQUEUE, 5, 8'h02, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    5, 8'h00, 8'h00, 3'b000, ST_BUSY));
        walk.push_back(make_item(CMD_POLL,    5, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    5, 8'h00, 8'h00, 3'b000, ST_SEND_FAIL));
        walk.push_back(make_item(CMD_POLL,    5, 8'h00, 8'h00, 3'b000, ST_ABSENT));
        // Module 31: empty mask, absent while checking ready.
        walk.push_back(make_item(CMD_ENQUEUE, 31, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    31, 8'h00, 8'h00, 3'b000, ST_ABSENT));
        walk.push_back(make_item(CMD_POLL,    31, 8'h00, 8'h00, 3'b000, ST_GOOD));
        // Module 0: status fail, enqueue while busy, absent in send, response fail.
        walk.push_back(make_item(CMD_ENQUEUE, 0, 8'hAA, 8'h55, 3'b010, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_BUSY));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_STATUS_FAIL));
        walk.push_back(make_item(CMD_ENQUEUE, 0, 8'h03, 8'hC3, 3'b101, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_ABSENT));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_RESP_FAIL));
        walk.push_back(make_item(CMD_POLL,    0, 8'h00, 8'h00, 3'b000, ST_GOOD));
        foreach (walk[i])
            offer_request(walk[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 27;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                // no idling; stall the result side so the input backs up
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_wanted   = 1;
            end
            offer_request(random_item());
        end
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d enqueues), %0d command blocks issued",
                 sb.n_requests, sb.n_enqueues, sb.n_blocks);
        $display("%0d failure results, mismatches: %0d, results still awaited: %0d",
                 sb.n_failures, sb.errors, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
